FILE: rtl/spm_pkg.sv
// Shared types, constants and helpers for the SPI port register model.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package spm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RECV  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_MASTER = 2'd1,
        REG_RATE   = 2'd2,
        REG_DOUBLE = 2'd3
    } reg_idx_t;

    localparam int CNT_W  = 11;
    localparam int ADDR_W = 4;

    typedef logic [7:0] divisor_t;
    localparam divisor_t DIVISORS [4] = '{8'd4, 8'd16, 8'd64, 8'd128};

    typedef struct packed {
        logic       spi_enable;
        logic       master_mode;
        logic [1:0] clock_rate_select;
        logic       double_speed;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       interrupt_raised;
        logic       flag_state;
    } res_t;

    // countdown length in ticks: 8 * divisor, divisor halved for double speed master
    function automatic logic [CNT_W-1:0] count_len(cfg_t cfg);
        logic [CNT_W-1:0] div;
        div = CNT_W'(DIVISORS[cfg.clock_rate_select]);
        if (cfg.master_mode && cfg.double_speed) begin
            div = div >> 1;
        end
        return div << 3;
    endfunction

endpackage

FILE: rtl/spm_apb_regs.sv
// APB configuration registers of the SPI port register model.
// Depends on spm_pkg (cfg_t, reg_idx_t, ADDR_W).
`timescale 1ns / 1ps

module spm_apb_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [spm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output spm_pkg::cfg_t             cfg
);

    spm_pkg::cfg_t    cfg_reg, cfg_next;
    spm_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = spm_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready) begin
            case (idx)
                spm_pkg::REG_ENABLE: cfg_next.spi_enable        = pwdata[0];
                spm_pkg::REG_MASTER: cfg_next.master_mode       = pwdata[0];
                spm_pkg::REG_RATE:   cfg_next.clock_rate_select = pwdata[1:0];
                spm_pkg::REG_DOUBLE: cfg_next.double_speed      = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            spm_pkg::REG_ENABLE: prdata = {31'd0, cfg_reg.spi_enable};
            spm_pkg::REG_MASTER: prdata = {31'd0, cfg_reg.master_mode};
            spm_pkg::REG_RATE:   prdata = {30'd0, cfg_reg.clock_rate_select};
            spm_pkg::REG_DOUBLE: prdata = {31'd0, cfg_reg.double_speed};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/spm_in_stage.sv
// Input register stage: holds one accepted beat until the core takes it.
// Depends on spm_pkg (op_t).
`timescale 1ns / 1ps

module spm_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_op,
    input  logic [7:0]    s_data_byte,
    output logic          valid,
    input  logic          take,
    output spm_pkg::op_t  op,
    output logic [7:0]    data_byte
);

    logic         valid_reg;
    spm_pkg::op_t op_reg;
    logic [7:0]   byte_reg;

    assign s_ready   = !valid_reg || take;
    assign valid     = valid_reg;
    assign op        = op_reg;
    assign data_byte = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= spm_pkg::op_t'(s_op);
            byte_reg <= s_data_byte;
        end
    end

endmodule

FILE: rtl/spm_core.sv
// Port state (data latches, countdown, busy, flag) and per-beat result logic.
// Depends on spm_pkg (op_t, cfg_t, res_t, count_len, CNT_W).
`timescale 1ns / 1ps

module spm_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  spm_pkg::op_t  op,
    input  logic [7:0]    data_byte,
    input  spm_pkg::cfg_t cfg,
    output spm_pkg::res_t res
);

    logic [7:0]                tx_reg, tx_next;
    logic [7:0]                rx_reg, rx_next;
    logic [spm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      flag_reg, flag_next;

    always_comb begin
        tx_next   = tx_reg;
        rx_next   = rx_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        flag_next = flag_reg;
        res       = '0;
        case (op)
            spm_pkg::OP_WRITE: begin
                tx_next   = data_byte;
                flag_next = 1'b0;
                cnt_next  = spm_pkg::count_len(cfg);
                busy_next = 1'b1;
            end
            spm_pkg::OP_READ: begin
                res.read_data = rx_reg;
                rx_next       = 8'd0;
                flag_next     = 1'b0;
            end
            spm_pkg::OP_RECV: begin
                if (cfg.spi_enable) begin
                    rx_next              = data_byte;
                    flag_next            = 1'b1;
                    res.interrupt_raised = 1'b1;
                    if (!cfg.master_mode) begin
                        res.send_valid = 1'b1;
                        res.send_byte  = tx_reg;
                    end
                end
            end
            spm_pkg::OP_TICK: begin
                if (busy_reg) begin
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    if (cnt_next == '0) begin
                        busy_next = 1'b0;
                        if (cfg.spi_enable && cfg.master_mode) begin
                            flag_next            = 1'b1;
                            res.interrupt_raised = 1'b1;
                            res.send_valid       = 1'b1;
                            res.send_byte        = tx_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.flag_state = flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg   <= 8'd0;
            rx_reg   <= 8'd0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            flag_reg <= 1'b0;
        end else if (advance) begin
            tx_reg   <= tx_next;
            rx_reg   <= rx_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            flag_reg <= flag_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("countdown nonzero while idle");
    a_send_has_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        res.send_valid |-> res.interrupt_raised)
        else $error("send without completion");
    a_irq_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.interrupt_raised) |=> flag_reg)
        else $error("completion did not set flag");
    a_send_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !res.send_valid |-> res.send_byte == 8'd0)
        else $error("send byte not cleared");
`endif

endmodule

FILE: rtl/spm_out_stage.sv
// Result register stage: holds one result beat until the sink takes it.
// Depends on spm_pkg (res_t).
`timescale 1ns / 1ps

module spm_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          valid,
    output logic          ready,
    input  spm_pkg::res_t res,
    output logic          m_valid,
    input  logic          m_ready,
    output spm_pkg::res_t m_res
);

    logic          valid_reg;
    spm_pkg::res_t res_reg;

    assign ready   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid && ready) begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/spi_port_register_model.sv
// Top level of the SPI port register model: input stage, core, result stage, APB registers.
// Depends on spm_pkg, spm_apb_regs, spm_in_stage, spm_core, spm_out_stage.
`timescale 1ns / 1ps

// Takes one operation beat per clock (write, read, partner byte or tick) and
// returns exactly one result beat for each, through the input register and then
// the result register. The rate is one beat per cycle when the sink is ready,
// set by the combinational update of the port state between the two registers;
// the sink stalling backs up both stages. Configuration is to be written through
// the APB port only while no beat is in flight; the user must ensure this, as the block does not enforce it.
module spi_port_register_model (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [spm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [7:0]                s_data_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_read_data,
    output logic                      m_send_valid,
    output logic [7:0]                m_send_byte,
    output logic                      m_interrupt_raised,
    output logic                      m_flag_state
);

    spm_pkg::cfg_t cfg;
    spm_pkg::op_t  op;
    spm_pkg::res_t res, m_res;
    logic [7:0]    data_byte;
    logic          in_valid, out_ready, advance;

    assign advance = in_valid && out_ready;

    spm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spm_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .valid       (in_valid),
        .take        (out_ready),
        .op          (op),
        .data_byte   (data_byte)
    );

    spm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .op        (op),
        .data_byte (data_byte),
        .cfg       (cfg),
        .res       (res)
    );

    spm_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid   (in_valid),
        .ready   (out_ready),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_read_data        = m_res.read_data;
    assign m_send_valid       = m_res.send_valid;
    assign m_send_byte        = m_res.send_byte;
    assign m_interrupt_raised = m_res.interrupt_raised;
    assign m_flag_state       = m_res.flag_state;

endmodule
